// ===== hw/rtl/pnr_pkg.sv =====
// Shared types and constants for the palette nearest-color remapper.
package pnr_pkg;

   // Request command codes.
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   // One memo cache entry: the pixel color looked up and the color it mapped to.
   typedef struct packed {
      rgb_type key;
      rgb_type val;
   } cache_entry_type;

   typedef struct packed {
      rgb_type old_color;
      rgb_type new_color;
   } pal_entry_type;

   typedef struct packed {
      logic          en;
      logic [7:0]    index;
      pal_entry_type entry;
   } pal_wr_type;

   typedef struct packed {
      logic    done;
      rgb_type color;
   } near_result_type;

endpackage

// ===== hw/rtl/pnr_if.sv =====
// Valid/ready channel interfaces for requests, responses and the control register.
interface pnr_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic       image_start;
   logic [7:0] entry_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic [7:0] new_red;
   logic [7:0] new_green;
   logic [7:0] new_blue;

   modport source (
      output valid, cmd, image_start, entry_index, red, green, blue, alpha,
             new_red, new_green, new_blue,
      input  ready
   );
   modport sink (
      input  valid, cmd, image_start, entry_index, red, green, blue, alpha,
             new_red, new_green, new_blue,
      output ready
   );
endinterface

interface pnr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic       cache_hit;
   logic       passed_through;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha, cache_hit, passed_through,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha, cache_hit, passed_through,
      output ready
   );
endinterface

interface pnr_csr_if;
   logic valid;
   logic ready;
   logic alpha_present;

   modport source (output valid, alpha_present, input ready);
   modport sink (input valid, alpha_present, output ready);
endinterface

// ===== hw/rtl/pnr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pnr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pnr_nearest.sv =====
// Palette store and nearest-entry search: one palette entry read and scored per cycle.
module pnr_nearest #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pnr_pkg::pal_wr_type      pal_wr,
   input  logic                     start,
   input  pnr_pkg::rgb_type         pix,
   output pnr_pkg::near_result_type result
);

   localparam int PAW  = $clog2(PALETTE_ENTRIES);
   localparam int PCW  = $clog2(PALETTE_ENTRIES + 1);
   localparam int SQW  = 16;
   localparam int DSTW = SQW + 2;
   localparam logic [PCW-1:0] PAL_LAST = PCW'(PALETTE_ENTRIES);

   function automatic logic [SQW-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQW'(d) * SQW'(d);
   endfunction

   logic                   wr_en;
   logic [PAW-1:0]         wr_addr;
   logic                   rd_en;
   logic [PAW-1:0]         rd_addr;
   logic [47:0]            rd_raw;
   pnr_pkg::pal_entry_type rd_entry;

   logic [PCW-1:0] pcnt_ff, pcnt_in;
   logic           busy_ff, busy_in;
   logic           s1v_ff, s1v_in;
   logic           s2v_ff, s2v_in;
   logic           done_ff, done_in;

   logic [SQW-1:0]         sqr_ff, sqr_in;
   logic [SQW-1:0]         sqg_ff, sqg_in;
   logic [SQW-1:0]         sqb_ff, sqb_in;
   pnr_pkg::pal_entry_type ent2_ff, ent2_in;
   logic [DSTW-1:0]        min_score_ff, min_score_in;
   pnr_pkg::pal_entry_type best_ff, best_in;
   logic [DSTW-1:0]        score;

   assign wr_en   = pal_wr.en && ({1'b0, pal_wr.index} < 9'(PALETTE_ENTRIES));
   assign wr_addr = pal_wr.index[PAW-1:0];
   assign rd_en   = busy_ff && (pcnt_ff < PAL_LAST);
   assign rd_addr = pcnt_ff[PAW-1:0];
   assign rd_entry = pnr_pkg::pal_entry_type'(rd_raw);

   pnr_ram #(
      .WIDTH ($bits(pnr_pkg::pal_entry_type)),
      .DEPTH (PALETTE_ENTRIES)
   ) u_pal_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (pal_wr.entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign score = DSTW'(sqr_ff) + DSTW'(sqg_ff) + DSTW'(sqb_ff);

   always_comb begin
      pcnt_in      = pcnt_ff;
      busy_in      = busy_ff;
      s1v_in       = rd_en;
      s2v_in       = s1v_ff;
      done_in      = 1'b0;
      sqr_in       = sqr_ff;
      sqg_in       = sqg_ff;
      sqb_in       = sqb_ff;
      ent2_in      = ent2_ff;
      min_score_in = min_score_ff;
      best_in      = best_ff;

      if (start) begin
         pcnt_in      = '0;
         busy_in      = 1'b1;
         min_score_in = '1;
      end else if (busy_ff) begin
         if (rd_en) begin
            pcnt_in = pcnt_ff + 1'b1;
         end else if (!s1v_ff && !s2v_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      if (s1v_ff) begin
         sqr_in  = sq_diff(rd_entry.old_color.r, pix.r);
         sqg_in  = sq_diff(rd_entry.old_color.g, pix.g);
         sqb_in  = sq_diff(rd_entry.old_color.b, pix.b);
         ent2_in = rd_entry;
      end

      // Strict compare keeps the lowest index on a tie.
      if (s2v_ff && (score < min_score_ff)) begin
         min_score_in = score;
         best_in      = ent2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= '0;
         busy_ff <= 1'b0;
         s1v_ff  <= 1'b0;
         s2v_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pcnt_ff <= pcnt_in;
         busy_ff <= busy_in;
         s1v_ff  <= s1v_in;
         s2v_ff  <= s2v_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sqr_ff       <= sqr_in;
      sqg_ff       <= sqg_in;
      sqb_ff       <= sqb_in;
      ent2_ff      <= ent2_in;
      min_score_ff <= min_score_in;
      best_ff      <= best_in;
   end

   assign result.done  = done_ff;
   assign result.color = (best_ff.old_color != best_ff.new_color) ? best_ff.new_color : pix;

endmodule

// ===== hw/rtl/palette_nearest_color_remap.sv =====
// Palette remapper top: request sequencer, memo cache memory and response register.
// A transparent pixel goes straight to the response register; a hit past the head first
// swaps that entry with the head. A miss shifts the entries down one place while the
// cache is not full, walks the palette one read per cycle and writes the result at the
// head. The next beat is taken in the cycle after the response loads.
// Synchronous reset empties the cache and clears the alpha mode; palettes are not cleared.
module palette_nearest_color_remap #(
   parameter int CACHE_ENTRIES   = 16,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic          clock,
   input  logic          reset,
   pnr_req_if.sink       req_bus,
   pnr_rsp_if.source     rsp_bus,
   pnr_csr_if.sink       csr_bus
);

   localparam int CAW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CCW = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CCW-1:0] CACHE_FULL = CCW'(CACHE_ENTRIES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CSRCH = 3'd1;
   localparam logic [2:0] ST_HIT0  = 3'd2;
   localparam logic [2:0] ST_HITJ  = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_WALK  = 3'd5;
   localparam logic [2:0] ST_MWR   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic [CCW-1:0] count_ff, count_in;
   logic           alpha_mode_ff, alpha_mode_in;
   logic [CCW-1:0] ccnt_ff, ccnt_in;
   logic           cv_ff, cv_in;
   logic [CAW-1:0] cidx_ff, cidx_in;
   logic [CCW-1:0] sh_ff, sh_in;
   logic           shv_ff, shv_in;
   logic [CAW-1:0] shaddr_ff, shaddr_in;
   logic           rsp_valid_ff, rsp_valid_in;

   pnr_pkg::rgb_type         pix_ff, pix_in;
   logic [7:0]               alpha_ff, alpha_in;
   pnr_pkg::rgb_type         res_ff, res_in;
   logic                     hit_ff, hit_in;
   logic                     pass_ff, pass_in;
   pnr_pkg::cache_entry_type head_ff, head_in;
   pnr_pkg::cache_entry_type hent_ff, hent_in;
   logic [CAW-1:0]           hidx_ff, hidx_in;
   pnr_pkg::rgb_type         out_res_ff, out_res_in;
   logic [7:0]               out_alpha_ff, out_alpha_in;
   logic                     out_hit_ff, out_hit_in;
   logic                     out_pass_ff, out_pass_in;

   logic                     req_fire;
   logic                     c_wr_en;
   logic [CAW-1:0]           c_wr_addr;
   pnr_pkg::cache_entry_type c_wr_data;
   logic                     c_rd_en;
   logic [CAW-1:0]           c_rd_addr;
   logic [47:0]              c_rd_raw;
   pnr_pkg::cache_entry_type c_rd_data;
   logic                     match;
   logic                     issue;
   logic                     near_start;
   pnr_pkg::near_result_type near_res;
   pnr_pkg::pal_wr_type      pal_wr;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign pal_wr.en                    = req_fire && (req_bus.cmd == pnr_pkg::CMD_LOAD);
   assign pal_wr.index                 = req_bus.entry_index;
   assign pal_wr.entry.old_color.r     = req_bus.red;
   assign pal_wr.entry.old_color.g     = req_bus.green;
   assign pal_wr.entry.old_color.b     = req_bus.blue;
   assign pal_wr.entry.new_color.r     = req_bus.new_red;
   assign pal_wr.entry.new_color.g     = req_bus.new_green;
   assign pal_wr.entry.new_color.b     = req_bus.new_blue;

   // Cache reads and writes run in separate phases, and the shift writes two entries
   // above the one it reads, so no read ever meets a write to the same entry.
   pnr_ram #(
      .WIDTH ($bits(pnr_pkg::cache_entry_type)),
      .DEPTH (CACHE_ENTRIES)
   ) u_cache_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (c_rd_en),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_raw)
   );

   assign c_rd_data = pnr_pkg::cache_entry_type'(c_rd_raw);

   pnr_nearest #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_nearest (
      .clock  (clock),
      .reset  (reset),
      .pal_wr (pal_wr),
      .start  (near_start),
      .pix    (pix_ff),
      .result (near_res)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      alpha_mode_in = alpha_mode_ff;
      ccnt_in       = ccnt_ff;
      cv_in         = 1'b0;
      cidx_in       = cidx_ff;
      sh_in         = sh_ff;
      shv_in        = 1'b0;
      shaddr_in     = shaddr_ff;
      rsp_valid_in  = rsp_valid_ff;
      pix_in        = pix_ff;
      alpha_in      = alpha_ff;
      res_in        = res_ff;
      hit_in        = hit_ff;
      pass_in       = pass_ff;
      head_in       = head_ff;
      hent_in       = hent_ff;
      hidx_in       = hidx_ff;
      out_res_in    = out_res_ff;
      out_alpha_in  = out_alpha_ff;
      out_hit_in    = out_hit_ff;
      out_pass_in   = out_pass_ff;
      c_wr_en       = 1'b0;
      c_wr_addr     = '0;
      c_wr_data     = head_ff;
      c_rd_en       = 1'b0;
      c_rd_addr     = '0;
      match         = 1'b0;
      issue         = 1'b0;
      near_start    = 1'b0;

      if (csr_bus.valid && csr_bus.ready) begin
         alpha_mode_in = csr_bus.alpha_present;
      end
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.image_start) begin
                  count_in = '0;
               end
               if (req_bus.cmd == pnr_pkg::CMD_PIXEL) begin
                  pix_in.r = req_bus.red;
                  pix_in.g = req_bus.green;
                  pix_in.b = req_bus.blue;
                  res_in   = pix_in;
                  alpha_in = alpha_mode_ff ? req_bus.alpha : 8'd0;
                  hit_in   = 1'b0;
                  pass_in  = alpha_mode_ff && (req_bus.alpha == 8'd0);
                  ccnt_in  = '0;
                  state_in = pass_in ? ST_OUT : ST_CSRCH;
               end
            end
         end
         ST_CSRCH: begin
            // Scan entries in MRU order; the compare works on the registered read data, in the cycle after the read.
            issue     = ccnt_ff < count_ff;
            c_rd_en   = issue;
            c_rd_addr = ccnt_ff[CAW-1:0];
            cv_in     = issue;
            cidx_in   = ccnt_ff[CAW-1:0];
            if (issue) begin
               ccnt_in = ccnt_ff + 1'b1;
            end
            match = cv_ff && (c_rd_data.key == pix_ff);
            if (cv_ff && (cidx_ff == '0)) begin
               head_in = c_rd_data;
            end
            if (match) begin
               hit_in   = 1'b1;
               hent_in  = c_rd_data;
               hidx_in  = cidx_ff;
               res_in   = c_rd_data.val;
               state_in = (cidx_ff == '0) ? ST_OUT : ST_HIT0;
            end else if (ccnt_ff == count_ff) begin
               if (count_ff < CACHE_FULL) begin
                  sh_in    = count_ff;
                  state_in = ST_SHIFT;
               end else begin
                  near_start = 1'b1;
                  state_in   = ST_WALK;
               end
            end
         end
         ST_HIT0: begin
            c_wr_en   = 1'b1;
            c_wr_addr = '0;
            c_wr_data = hent_ff;
            state_in  = ST_HITJ;
         end
         ST_HITJ: begin
            c_wr_en   = 1'b1;
            c_wr_addr = hidx_ff;
            c_wr_data = head_ff;
            state_in  = ST_OUT;
         end
         ST_SHIFT: begin
            // Move entries down one place, last entry first.
            issue     = sh_ff != '0;
            c_rd_en   = issue;
            c_rd_addr = CAW'(sh_ff - 1'b1);
            shv_in    = issue;
            shaddr_in = c_rd_addr;
            if (issue) begin
               sh_in = sh_ff - 1'b1;
            end
            if (shv_ff) begin
               c_wr_en   = 1'b1;
               c_wr_addr = shaddr_ff + 1'b1;
               c_wr_data = c_rd_data;
            end
            if (!issue && !shv_ff) begin
               count_in   = count_ff + 1'b1;
               near_start = 1'b1;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            if (near_res.done) begin
               res_in   = near_res.color;
               state_in = ST_MWR;
            end
         end
         ST_MWR: begin
            c_wr_en       = 1'b1;
            c_wr_addr     = '0;
            c_wr_data.key = pix_ff;
            c_wr_data.val = res_ff;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_res_in   = res_ff;
               out_alpha_in = alpha_ff;
               out_hit_in   = hit_ff;
               out_pass_in  = pass_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         alpha_mode_ff <= 1'b0;
         ccnt_ff       <= '0;
         cv_ff         <= 1'b0;
         sh_ff         <= '0;
         shv_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         alpha_mode_ff <= alpha_mode_in;
         ccnt_ff       <= ccnt_in;
         cv_ff         <= cv_in;
         sh_ff         <= sh_in;
         shv_ff        <= shv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cidx_ff      <= cidx_in;
      shaddr_ff    <= shaddr_in;
      pix_ff       <= pix_in;
      alpha_ff     <= alpha_in;
      res_ff       <= res_in;
      hit_ff       <= hit_in;
      pass_ff      <= pass_in;
      head_ff      <= head_in;
      hent_ff      <= hent_in;
      hidx_ff      <= hidx_in;
      out_res_ff   <= out_res_in;
      out_alpha_ff <= out_alpha_in;
      out_hit_ff   <= out_hit_in;
      out_pass_ff  <= out_pass_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_red        = out_res_ff.r;
   assign rsp_bus.out_green      = out_res_ff.g;
   assign rsp_bus.out_blue       = out_res_ff.b;
   assign rsp_bus.out_alpha      = out_alpha_ff;
   assign rsp_bus.cache_hit      = out_hit_ff;
   assign rsp_bus.passed_through = out_pass_ff;

endmodule

// ===== hw/rtl/pnr_checker.sv =====
// Port-level assertions for the palette remapper, bound to the top level.
module pnr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_alpha,
   input logic       rsp_cache_hit,
   input logic       rsp_passed_through
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cache_hit && rsp_passed_through))
      else $error("pass-through beat flagged as cache hit");

   a_pass_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_passed_through |-> (rsp_out_alpha == 8'd0))
      else $error("pass-through beat with nonzero alpha");

   // A load beat leaves the block idle, so no response can appear right after it.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == pnr_pkg::CMD_LOAD) |=> !$rose(rsp_valid))
      else $error("response raised after a palette load");

   // A taken pixel takes the block out of idle and drops request ready.
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == pnr_pkg::CMD_PIXEL) |=> !req_ready)
      else $error("request taken while a pixel is in work");

endmodule

bind palette_nearest_color_remap pnr_checker u_pnr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_cmd            (req_bus.cmd),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_out_alpha      (rsp_bus.out_alpha),
   .rsp_cache_hit      (rsp_bus.cache_hit),
   .rsp_passed_through (rsp_bus.passed_through)
);
